>>> rtl/gap_pair_histogram_core_macros.svh
// Assertion macros shared by the gap-pair histogram RTL.
// Needs a clock named clk and an active-high synchronous reset named rst in scope.
`ifndef GAP_PAIR_HISTOGRAM_CORE_MACROS_SVH
`define GAP_PAIR_HISTOGRAM_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GPH_CHECK(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gap_pair_histogram_core: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define GPH_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gap_pair_histogram_core: next-cycle check failed");

`endif

>>> rtl/gph_pkg.sv
// Shared types, constants and helpers for the gap-pair histogram.
// No dependencies; used by gph_ctrl, gph_datapath and the top level.
`default_nettype none

package gph_pkg;

  localparam int MAX_GAP_DEFAULT    = 15;
  localparam int INDEX_BITS_DEFAULT = 16;

  localparam int RESIDUE_W = 16;
  localparam int COORD_W   = 4;
  localparam int LIMIT_W   = 4;
  localparam int COUNT_W   = 32;

  localparam logic [LIMIT_W-1:0] GAP_LIMIT_RESET = 4'd15;

  typedef enum logic [1:0] {
    CMD_RESIDUE = 2'd0,
    CMD_READ    = 2'd1,
    CMD_CLEAR   = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_FETCH,
    ST_CLEAR,
    ST_COMMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic mem_read;
    logic sweep;
    logic commit;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic is_clear;
    logic sweep_last;
    logic out_free;
  } status_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (v == '1) ? v : v + COUNT_W'(1);
  endfunction

endpackage

`default_nettype wire

>>> rtl/gph_ctrl.sv
// Sequencing state machine for the gap-pair histogram.
// Depends on gph_pkg; drives gph_datapath through ctrl_t, watches status_t.
`default_nettype none

module gph_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  gph_pkg::status_t      status,
  output gph_pkg::ctrl_t        cmd
);

  gph_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gph_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      gph_pkg::ST_INIT: begin
        if (status.sweep_last) state_next = gph_pkg::ST_IDLE;
      end
      gph_pkg::ST_IDLE: begin
        if (in_valid) state_next = gph_pkg::ST_FETCH;
      end
      gph_pkg::ST_FETCH: begin
        state_next = status.is_clear ? gph_pkg::ST_CLEAR : gph_pkg::ST_COMMIT;
      end
      gph_pkg::ST_CLEAR: begin
        if (status.sweep_last) state_next = gph_pkg::ST_COMMIT;
      end
      gph_pkg::ST_COMMIT: begin
        if (status.out_free) state_next = gph_pkg::ST_IDLE;
      end
      default: begin
        state_next = gph_pkg::ST_INIT;
      end
    endcase
  end

  always_comb begin
    in_ready     = (state == gph_pkg::ST_IDLE);
    cmd.load     = in_ready && in_valid;
    cmd.mem_read = (state == gph_pkg::ST_FETCH);
    cmd.sweep    = (state == gph_pkg::ST_INIT) || (state == gph_pkg::ST_CLEAR);
    cmd.commit   = (state == gph_pkg::ST_COMMIT) && status.out_free;
  end

endmodule

`default_nettype wire

>>> rtl/gph_datapath.sv
// Datapath: item registers, sequence state, bin memory, counters, output register.
// Depends on gph_pkg and gap_pair_histogram_core_macros.svh; sequenced by gph_ctrl.
`default_nettype none
`include "gap_pair_histogram_core_macros.svh"

module gph_datapath #(
  parameter int MAX_GAP    = gph_pkg::MAX_GAP_DEFAULT,
  parameter int INDEX_BITS = gph_pkg::INDEX_BITS_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  gph_pkg::ctrl_t                      cmd,
  output gph_pkg::status_t                    status,
  input  wire logic                           cfg_write,
  input  wire logic [gph_pkg::LIMIT_W-1:0]    cfg_data,
  input  wire logic [1:0]                     command,
  input  wire logic [gph_pkg::RESIDUE_W-1:0]  residue,
  input  wire logic                           end_of_sequence,
  input  wire logic [gph_pkg::COORD_W-1:0]    read_insertions,
  input  wire logic [gph_pkg::COORD_W-1:0]    read_deletions,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                gap_recorded,
  output logic                                gap_overflowed,
  output logic [gph_pkg::COUNT_W-1:0]         bin_count,
  output logic [gph_pkg::COUNT_W-1:0]         overflow_total,
  output logic [gph_pkg::COUNT_W-1:0]         gap_total
);

  localparam int SIDE   = MAX_GAP + 1;
  localparam int DEPTH  = SIDE * SIDE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SIDE_W = $clog2(SIDE);
  localparam int IDX_W  = (INDEX_BITS < gph_pkg::RESIDUE_W) ? INDEX_BITS : gph_pkg::RESIDUE_W;
  // run only needs to reach one past the largest binnable count
  localparam int RUN_W  = $clog2(MAX_GAP + 2);
  localparam logic [RUN_W-1:0] RUN_SAT = RUN_W'(MAX_GAP + 1);

  localparam int CW = gph_pkg::COUNT_W;

  // config
  logic [gph_pkg::LIMIT_W-1:0] gap_limit;

  // item registers
  gph_pkg::cmd_t                cmd_q;
  logic [IDX_W-1:0]             res_q;
  logic                         eos_q;
  logic [gph_pkg::COORD_W-1:0]  rd_ins_q;
  logic [gph_pkg::COORD_W-1:0]  rd_del_q;

  // sequence state and counters
  logic [IDX_W-1:0] prev_index, prev_index_next;
  logic             have_prev, have_prev_next;
  logic [RUN_W-1:0] run, run_next;
  logic [CW-1:0]    ovf_cnt, ovf_cnt_next;
  logic [CW-1:0]    gap_cnt, gap_cnt_next;

  // bin store
  logic [CW-1:0]     mem [DEPTH];
  logic [CW-1:0]     rd_data;
  logic [ADDR_W-1:0] sweep_addr;
  logic [ADDR_W-1:0] bin_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [CW-1:0]     wr_data;
  logic              wr_en;

  logic [gph_pkg::LIMIT_W-1:0] eff_limit;
  logic [IDX_W-1:0]  dels;
  logic              binned;
  logic              rd_in_range;
  logic [SIDE_W-1:0] row, col;
  logic [CW-1:0]     bin_inc;
  logic              bin_we;
  logic              rec, ovfd;
  logic [CW-1:0]     count;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_limit <= gph_pkg::GAP_LIMIT_RESET;
    end else if (cfg_write) begin
      gap_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q    <= gph_pkg::cmd_t'(command);
      res_q    <= residue[IDX_W-1:0];
      eos_q    <= end_of_sequence;
      rd_ins_q <= read_insertions;
      rd_del_q <= read_deletions;
    end
  end

  // gap classification and bin address
  always_comb begin
    eff_limit   = (int'(gap_limit) < MAX_GAP) ? gap_limit : gph_pkg::LIMIT_W'(MAX_GAP);
    dels        = res_q - prev_index - IDX_W'(1);
    binned      = (res_q > prev_index) && (int'(run) <= int'(eff_limit)) &&
                  (dels <= IDX_W'(eff_limit));
    rd_in_range = (int'(rd_ins_q) <= MAX_GAP) && (int'(rd_del_q) <= MAX_GAP);
    row         = (cmd_q == gph_pkg::CMD_READ) ? SIDE_W'(rd_ins_q) : SIDE_W'(run);
    col         = (cmd_q == gph_pkg::CMD_READ) ? SIDE_W'(rd_del_q) : SIDE_W'(dels);
    bin_addr    = ADDR_W'(row) * ADDR_W'(SIDE) + ADDR_W'(col);
    bin_inc     = gph_pkg::sat_inc(rd_data);
  end

  // commit-time next values
  always_comb begin
    prev_index_next = prev_index;
    have_prev_next  = have_prev;
    run_next        = run;
    ovf_cnt_next    = ovf_cnt;
    gap_cnt_next    = gap_cnt;
    bin_we          = 1'b0;
    rec             = 1'b0;
    ovfd            = 1'b0;
    count           = '0;
    unique case (cmd_q)
      gph_pkg::CMD_RESIDUE: begin
        if (res_q == '0) begin
          if (have_prev && (run != RUN_SAT)) run_next = run + RUN_W'(1);
        end else begin
          if (have_prev) begin
            if (binned) begin
              bin_we = 1'b1;
              count  = bin_inc;
              rec    = 1'b1;
            end else begin
              ovf_cnt_next = gph_pkg::sat_inc(ovf_cnt);
              ovfd         = 1'b1;
            end
            gap_cnt_next = gph_pkg::sat_inc(gap_cnt);
          end
          prev_index_next = res_q;
          have_prev_next  = 1'b1;
          run_next        = '0;
        end
        if (eos_q) begin
          have_prev_next = 1'b0;
          run_next       = '0;
        end
      end
      gph_pkg::CMD_READ: begin
        if (rd_in_range) count = rd_data;
      end
      gph_pkg::CMD_CLEAR: begin
        ovf_cnt_next = '0;
        gap_cnt_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_index <= '0;
      have_prev  <= 1'b0;
      run        <= '0;
      ovf_cnt    <= '0;
      gap_cnt    <= '0;
    end else if (cmd.commit) begin
      prev_index <= prev_index_next;
      have_prev  <= have_prev_next;
      run        <= run_next;
      ovf_cnt    <= ovf_cnt_next;
      gap_cnt    <= gap_cnt_next;
    end
  end

  // single write port: clearing sweep or bin update
  always_comb begin
    wr_en   = cmd.sweep || (cmd.commit && bin_we);
    wr_addr = cmd.sweep ? sweep_addr : bin_addr;
    wr_data = cmd.sweep ? '0 : bin_inc;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.mem_read) begin
      rd_data <= mem[bin_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
    end else if (cmd.sweep) begin
      sweep_addr <= status.sweep_last ? '0 : sweep_addr + ADDR_W'(1);
    end
  end

  always_comb begin
    status.is_clear   = (cmd_q == gph_pkg::CMD_CLEAR);
    status.sweep_last = (sweep_addr == ADDR_W'(DEPTH - 1));
    status.out_free   = !out_valid || out_ready;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      gap_recorded   <= rec;
      gap_overflowed <= ovfd;
      bin_count      <= count;
      overflow_total <= ovf_cnt_next;
      gap_total      <= gap_cnt_next;
    end
  end

  `GPH_CHECK(a_flags_exclusive, out_valid, !(gap_recorded && gap_overflowed))
  `GPH_CHECK(a_recorded_bin_nonzero, out_valid && gap_recorded, bin_count != '0)
  `GPH_CHECK(a_run_needs_anchor, !have_prev, run == '0)
  `GPH_CHECK(a_commit_into_free_slot, cmd.commit, !out_valid || out_ready)
  `GPH_CHECK_NEXT(a_gap_total_step, cmd.commit && (cmd_q != gph_pkg::CMD_CLEAR), (gap_cnt == $past(gap_cnt)) || (gap_cnt == $past(gap_cnt) + 32'd1))

endmodule

`default_nettype wire

>>> rtl/gap_pair_histogram_core.sv
// Gap-pair histogram core. Each transaction steps through accept, bin-store read and
// update/commit; commit stalls while the previous result has not been taken, and a new
// transaction is accepted only after commit. A clear adds a sweep of the store, one entry
// per cycle. Reset (synchronous) runs the same sweep with in_ready low; config writes are
// taken throughout. gap_limit resets to 15.
// Depends on gph_pkg, gph_ctrl and gph_datapath.
`default_nettype none

module gap_pair_histogram_core #(
  parameter int MAX_GAP    = gph_pkg::MAX_GAP_DEFAULT,    // 1..63
  parameter int INDEX_BITS = gph_pkg::INDEX_BITS_DEFAULT  // 4..32, residue bits used (at most 16)
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // configuration: gap_limit
  input  wire logic                           cfg_write,
  input  wire logic [gph_pkg::LIMIT_W-1:0]    cfg_data,
  // input transactions
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     command,
  input  wire logic [gph_pkg::RESIDUE_W-1:0]  residue,
  input  wire logic                           end_of_sequence,
  input  wire logic [gph_pkg::COORD_W-1:0]    read_insertions,
  input  wire logic [gph_pkg::COORD_W-1:0]    read_deletions,
  // result transactions
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                gap_recorded,
  output logic                                gap_overflowed,
  output logic [gph_pkg::COUNT_W-1:0]         bin_count,
  output logic [gph_pkg::COUNT_W-1:0]         overflow_total,
  output logic [gph_pkg::COUNT_W-1:0]         gap_total
);

  // Controller steps each transaction through fetch and commit:
  //   fetch  - the bin store is read at (insertions, deletions) of the gap
  //            being closed, or at the requested coordinate for a read;
  //   commit - saturating increment written back (or overflow counter bumped),
  //            sequence state advanced, result loaded into the output register.
  // A clear command detours through a full zeroing sweep before commit.
  // The output register frees the input side: a new transaction is accepted
  // while the previous result still waits for out_ready; commit only stalls
  // if that result has not been taken by then.
  gph_pkg::ctrl_t   cmd;
  gph_pkg::status_t status;

  gph_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath holds the bin store ((MAX_GAP+1)^2 x 32 bits, one write and one
  // registered read port), the previous index / insertion run of the current
  // trial, the overflow and gap totals, and the gap_limit register.
  gph_datapath #(
    .MAX_GAP    (MAX_GAP),
    .INDEX_BITS (INDEX_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg_data),
    .command         (command),
    .residue         (residue),
    .end_of_sequence (end_of_sequence),
    .read_insertions (read_insertions),
    .read_deletions  (read_deletions),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .gap_recorded    (gap_recorded),
    .gap_overflowed  (gap_overflowed),
    .bin_count       (bin_count),
    .overflow_total  (overflow_total),
    .gap_total       (gap_total)
  );

endmodule

`default_nettype wire

>>> test/gap_pair_histogram_core_tb.sv
// Self-checking testbench for gap_pair_histogram_core: directed gap cases, gap_limit sweeps,
// a saturating insertion run and random sequence traffic, each transaction checked in order.
// Depends on gph_pkg and the gap_pair_histogram_core RTL; needs no files or arguments.
module gap_pair_histogram_core_tb;

  localparam int MAX_GAP        = gph_pkg::MAX_GAP_DEFAULT;
  localparam int INDEX_BITS     = gph_pkg::INDEX_BITS_DEFAULT;
  localparam int COUNT_W        = gph_pkg::COUNT_W;
  localparam int LIMIT_W        = gph_pkg::LIMIT_W;
  localparam int RESIDUE_W      = gph_pkg::RESIDUE_W;
  localparam int COORD_W        = gph_pkg::COORD_W;
  localparam int SIDE           = MAX_GAP + 1;
  localparam int RESET_CYCLES   = 12;
  localparam int DRAIN_CYCLES   = 8;     // margin after the last result is taken
  localparam int QUIET_LIMIT    = 3000;  // well above a clear/reset sweep plus the longest random stall
  localparam int RANDOM_ITEMS   = 1500;
  localparam int RANDOM_PHASES  = 6;
  localparam int LONG_RUN       = 40;    // well past any limit and past a narrow run counter

  // command 3 is not decoded by the block
  localparam logic [1:0] CMD_SPARE = 2'd3;

  typedef struct packed {
    logic                recorded;
    logic                overflowed;
    logic [COUNT_W-1:0]  count;
    logic [COUNT_W-1:0]  overflow_total;
    logic [COUNT_W-1:0]  gap_total;
  } gap_result_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  logic [LIMIT_W-1:0]    cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [1:0]            command;
  logic [RESIDUE_W-1:0]  residue;
  logic                  end_of_sequence;
  logic [COORD_W-1:0]    read_insertions;
  logic [COORD_W-1:0]    read_deletions;
  logic                  out_valid;
  logic                  out_ready;
  logic                  gap_recorded;
  logic                  gap_overflowed;
  logic [COUNT_W-1:0]    bin_count;
  logic [COUNT_W-1:0]    overflow_total;
  logic [COUNT_W-1:0]    gap_total;

  // Histogram mirror: sequence tracking, pair tallies and the two totals
  logic [LIMIT_W-1:0]    gap_limit_now;
  logic [RESIDUE_W-1:0]  prev_idx;
  logic                  have_prev;
  logic [15:0]           ins_run;
  logic [COUNT_W-1:0]    pair_tally [SIDE*SIDE];
  logic [COUNT_W-1:0]    overflow_tally;
  logic [COUNT_W-1:0]    gap_tally;

  // One expected result per accepted transaction, oldest first
  gap_result_t           pending_results [$];

  int unsigned           error_count;
  int unsigned           items_sent;
  int unsigned           results_checked;
  int unsigned           gaps_binned;
  int unsigned           gaps_overflowed;
  int unsigned           reads_done;
  int unsigned           clears_done;
  bit                    source_idling;
  bit                    sink_idling;

  always #2 clk = ~clk;

  gap_pair_histogram_core #(
    .MAX_GAP         (MAX_GAP),
    .INDEX_BITS      (INDEX_BITS)
  ) dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .command         (command),
    .residue         (residue),
    .end_of_sequence (end_of_sequence),
    .read_insertions (read_insertions),
    .read_deletions  (read_deletions),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .gap_recorded    (gap_recorded),
    .gap_overflowed  (gap_overflowed),
    .bin_count       (bin_count),
    .overflow_total  (overflow_total),
    .gap_total       (gap_total)
  );

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic void clear_histogram();
    foreach (pair_tally[i]) pair_tally[i] = '0;
    overflow_tally = '0;
    gap_tally = '0;
  endfunction

  // Advances the mirror by one transaction and returns what the block should report.
  function automatic gap_result_t histogram_step(input logic [1:0] cmd,
      input logic [RESIDUE_W-1:0] res, input logic eos,
      input logic [COORD_W-1:0] ri, input logic [COORD_W-1:0] rdl);
    gap_result_t r;
    int lim;
    int dels;
    int slot;
    bit binned;
    r = '0;
    lim = (int'(gap_limit_now) < MAX_GAP) ? int'(gap_limit_now) : MAX_GAP;
    case (cmd)
      gph_pkg::CMD_RESIDUE: begin
        if (res == '0) begin
          // insertions only count once a trial has an ancestral anchor
          if (have_prev && ins_run != 16'hFFFF) ins_run++;
        end else begin
          if (have_prev) begin
            binned = 1'b0;
            dels = 0;
            // a non-increasing index is a broken gap: always overflow
            if (res > prev_idx) begin
              dels = int'(res) - int'(prev_idx) - 1;
              binned = (int'(ins_run) <= lim) && (dels <= lim);
            end
            if (binned) begin
              slot = int'(ins_run) * SIDE + dels;
              pair_tally[slot] = bump(pair_tally[slot]);
              r.count = pair_tally[slot];
              r.recorded = 1'b1;
              gaps_binned++;
            end else begin
              overflow_tally = bump(overflow_tally);
              r.overflowed = 1'b1;
              gaps_overflowed++;
            end
            gap_tally = bump(gap_tally);
          end
          prev_idx = res;
          have_prev = 1'b1;
          ins_run = '0;
        end
        if (eos) begin
          have_prev = 1'b0;
          ins_run = '0;
        end
      end
      gph_pkg::CMD_READ: begin
        // 4-bit coordinates never exceed MAX_GAP at the default size
        if (int'(ri) <= MAX_GAP && int'(rdl) <= MAX_GAP) r.count = pair_tally[ri * SIDE + rdl];
        reads_done++;
      end
      gph_pkg::CMD_CLEAR: begin
        // counts only; the open trial carries on
        clear_histogram();
        clears_done++;
      end
      default: begin
      end
    endcase
    r.overflow_total = overflow_tally;
    r.gap_total = gap_tally;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Presents one transaction and holds it until taken. Valid is left high so a
  // following call in the same step chains straight on; settle() drops it.
  task automatic send_item(input logic [1:0] cmd, input logic [RESIDUE_W-1:0] res,
      input logic eos, input logic [COORD_W-1:0] ri, input logic [COORD_W-1:0] rdl);
    gap_result_t expected;
    if (source_idling && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    command         <= cmd;
    residue         <= res;
    end_of_sequence <= eos;
    read_insertions <= ri;
    read_deletions  <= rdl;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    expected = histogram_step(cmd, res, eos, ri, rdl);
    pending_results = {pending_results, expected};
  endtask

  task automatic send_residue(input logic [RESIDUE_W-1:0] res, input logic eos);
    send_item(gph_pkg::CMD_RESIDUE, res, eos, COORD_W'($urandom), COORD_W'($urandom));
  endtask

  task automatic send_read(input logic [COORD_W-1:0] ri, input logic [COORD_W-1:0] rdl,
      input logic eos);
    send_item(gph_pkg::CMD_READ, RESIDUE_W'($urandom), eos, ri, rdl);
  endtask

  // Inserted residues then the ancestral index that closes the gap. Opens a
  // fresh trial first if none is running.
  task automatic send_gap(input int ins, input int dels, input logic eos);
    if (!have_prev) send_residue(RESIDUE_W'($urandom_range(1, 16'h7000)), 1'b0);
    repeat (ins) send_residue('0, 1'b0);
    send_residue(prev_idx + RESIDUE_W'(dels) + 1'b1, eos);
  endtask

  // Quiesce: nothing in flight, nothing left to come out.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_gap_limit(input logic [LIMIT_W-1:0] v);
    settle();
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    gap_limit_now = v;
  endtask

  // Mostly within the current limit, now and then just past it
  function automatic int pick_count();
    if ($urandom_range(0, 9) == 0) return int'(gap_limit_now) + $urandom_range(1, 3);
    return $urandom_range(0, gap_limit_now);
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    if ($urandom_range(0, 9) < 6) return COORD_W'($urandom_range(0, gap_limit_now));
    return COORD_W'($urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked cases at the reset limit of 15
  task automatic test_directed_cases();
    send_read(4'd0, 4'd0, 1'b0);               // empty store
    send_read(4'd15, 4'd15, 1'b0);
    send_item(CMD_SPARE, 16'hFFFF, 1'b1, 4'd15, 4'd15);  // unused command: no effect
    send_residue(16'd0, 1'b0);                 // leading insertion, dropped
    send_residue(16'd1, 1'b0);                 // first anchor, no gap yet
    send_residue(16'd0, 1'b0);
    send_residue(16'd0, 1'b0);
    send_residue(16'd5, 1'b0);                 // 2 insertions, 3 deletions
    send_residue(16'd6, 1'b0);                 // back-to-back hit on (0,0)
    send_residue(16'd6, 1'b0);                 // repeated index -> overflow
    send_residue(16'd3, 1'b0);                 // going backwards -> overflow
    send_residue(16'd19, 1'b0);                // 15 deletions, on the limit
    send_residue(16'd36, 1'b0);                // 16 deletions, just over
    send_residue(16'hFFFF, 1'b1);              // top index, closes the trial
    send_residue(16'd0, 1'b0);                 // trailing insertion, dropped
    send_residue(16'h8000, 1'b0);
    send_read(4'd2, 4'd3, 1'b1);               // end flag ignored on a read
    send_residue(16'h8001, 1'b0);              // so the trial is still open
    send_item(gph_pkg::CMD_CLEAR, 16'h5A5A, 1'b1, 4'd15, 4'd0);
    send_residue(16'h8002, 1'b0);              // sequence state survives a clear
    send_read(4'd0, 4'd0, 1'b0);
    send_read(4'd2, 4'd3, 1'b0);
    send_residue(16'h8003, 1'b1);
    settle();
  endtask

  // Binning boundary on each side of several gap_limit settings
  task automatic test_gap_limit_edges();
    logic [LIMIT_W-1:0] limits [6];
    int lim;
    limits = '{4'd0, 4'd15, 4'd1, 4'd8, 4'd14, LIMIT_W'($urandom)};
    foreach (limits[k]) begin
      set_gap_limit(limits[k]);
      lim = int'(limits[k]);
      send_gap(lim, lim, 1'b0);                // corner bin
      send_gap(lim + 1, 0, 1'b0);              // insertions over
      send_gap(0, lim + 1, 1'b0);              // deletions over
      send_gap(lim, 0, 1'b0);
      send_gap(0, lim, 1'b0);
      send_read(COORD_W'(lim), COORD_W'(lim), 1'b0);
      send_read(COORD_W'(lim), 4'd0, 1'b0);
      send_gap(lim + 1, lim + 1, 1'b1);        // both over, ends the trial
    end
    settle();
  endtask

  // Insertion counter must stick at its top value rather than wrap to a binnable count
  task automatic test_long_insertion_run();
    source_idling = 1'b0;
    sink_idling = 1'b0;
    set_gap_limit(4'd15);
    send_residue(16'h1000, 1'b1);              // close whatever is open
    send_residue(16'h1000, 1'b0);
    repeat (LONG_RUN) send_residue('0, 1'b0);
    send_residue(16'h1001, 1'b1);
    send_read(4'd1, 4'd0, 1'b0);
    settle();
  endtask

  // Mostly well-formed trials with random content, plus reads, clears and noise
  task automatic test_random_traffic();
    int phase;
    int target;
    int roll;
    int gaps;
    int g;
    logic [RESIDUE_W-1:0] idx;
    logic [RESIDUE_W-1:0] next_idx;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0) set_gap_limit(4'd0);
      else if (phase == 1) set_gap_limit(4'd15);
      else set_gap_limit(LIMIT_W'($urandom));
      // last phase runs flat out on both sides
      source_idling = (phase != RANDOM_PHASES - 1);
      sink_idling = (phase != RANDOM_PHASES - 1);
      target = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
      while (items_sent < target) begin
        if (phase != RANDOM_PHASES - 1 && $urandom_range(0, 24) == 0) begin
          source_idling = !source_idling;
          sink_idling = 1'($urandom_range(0, 1));
        end
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
          // start kept low enough that 12 gaps of up to 18 deletions stay in range
          gaps = $urandom_range(1, 12);
          idx = RESIDUE_W'($urandom_range(1, 16'hFE00));
          repeat ($urandom_range(0, 2)) send_residue('0, 1'b0);
          send_residue(idx, 1'b0);
          for (g = 0; g < gaps; g++) begin
            repeat (pick_count()) send_residue('0, 1'b0);
            if ($urandom_range(0, 19) == 0) next_idx = RESIDUE_W'($urandom_range(1, idx));
            else next_idx = idx + RESIDUE_W'(pick_count()) + 1'b1;
            send_residue(next_idx, g == gaps - 1);
            idx = next_idx;
          end
          if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) send_residue('0, 1'b0);
        end else if (roll < 85) begin
          send_read(pick_coord(), pick_coord(), 1'($urandom_range(0, 1)));
        end else if (roll < 89) begin
          send_item(CMD_SPARE, RESIDUE_W'($urandom), 1'($urandom_range(0, 1)),
                    COORD_W'($urandom), COORD_W'($urandom));
        end else if (roll < 98) begin
          // noise: any index, often zero, random end flag
          send_residue(($urandom_range(0, 2) == 0) ? '0 : RESIDUE_W'($urandom),
                       $urandom_range(0, 3) == 0);
        end else if (roll < 99) begin
          send_item(gph_pkg::CMD_CLEAR, RESIDUE_W'($urandom), 1'($urandom_range(0, 1)),
                    COORD_W'($urandom), COORD_W'($urandom));
        end else begin
          send_read(COORD_W'($urandom), COORD_W'($urandom), 1'b0);
        end
      end
    end
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Random back-pressure in bursts, only while sink_idling is set
  initial begin : result_sink
    int unsigned hold;
    out_ready = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold != 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
        if (sink_idling && $urandom_range(0, 5) == 0) hold = $urandom_range(1, 14);
      end
    end
  end

  task automatic check_field(input string name, input logic [COUNT_W-1:0] want,
      input logic [COUNT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Sampled at the edge, so values are those before the edge's updates
  always @(posedge clk) begin : result_check
    gap_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transaction: expected none, actual count %0h",
                 $time, bin_count);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("gap_recorded", want.recorded, gap_recorded);
        check_field("gap_overflowed", want.overflowed, gap_overflowed);
        check_field("bin_count", want.count, bin_count);
        check_field("overflow_total", want.overflow_total, overflow_total);
        check_field("gap_total", want.gap_total, gap_total);
        results_checked++;
      end
    end
  end

  // Ends the run if no transaction moves on either side for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transaction for %0d cycles, %0d results outstanding",
             $time, QUIET_LIMIT, pending_results.size());
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    command = gph_pkg::CMD_RESIDUE;
    residue = '0;
    end_of_sequence = 1'b0;
    read_insertions = '0;
    read_deletions = '0;
    error_count = 0;
    items_sent = 0;
    results_checked = 0;
    gaps_binned = 0;
    gaps_overflowed = 0;
    reads_done = 0;
    clears_done = 0;
    source_idling = 1'b1;
    sink_idling = 1'b1;
    gap_limit_now = gph_pkg::GAP_LIMIT_RESET;
    prev_idx = '0;
    have_prev = 1'b0;
    ins_run = '0;
    clear_histogram();

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_gap_limit_edges();
    test_long_insertion_run();
    test_random_traffic();
    settle();

    $display("Covered %0d transactions, %0d results checked: %0d gaps binned, %0d overflowed,",
             items_sent, results_checked, gaps_binned, gaps_overflowed);
    $display("%0d bin reads, %0d clears, gap limits 0 to 15 and a saturated insertion run",
             reads_done, clears_done);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
